// ----- rtl/wmf_pkg.sv -----
package wmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 3;
  localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
  localparam int WIN_MAX    = WIN_SIDE * WIN_SIDE;
  localparam int LS_DEPTH   = WIN_SIDE * MAX_WIDTH;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 11;
  localparam int COL_W  = 10;
  localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int ADDR_W = $clog2(LS_DEPTH);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SIDE_W = $clog2(WIN_SIDE + 1);
  localparam int CNT_W  = $clog2(WIN_MAX + 1);
  localparam int LAG_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int IDX_W  = 2;
  localparam int SPAN_W = 3;

  typedef logic [PIX_W-1:0] pix_t;

  // Command broadcast to every cell of the sorting chain.
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } wmf_cmd_t;

  localparam logic [IDX_W-1:0] REG_SPAN   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage

// ----- rtl/window_median_filter.sv -----
// An item that yields a result shows it once the line store, read once per cycle, has fed
// the n samples of the clipped window (n up to 49) into the sorting chain and the chain
// has shifted n/2 times (rounded down) toward its head. Items with no result pass only
// through the decide state; a pixel dropped after the frame is complete stays in idle.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset clears positions and loads the default sizes; input stalls while the derived sizes
// settle after reset and after each write. The line store is not cleared.
module window_median_filter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [wmf_pkg::PIX_W-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [wmf_pkg::PIX_W-1:0] out_median,
  output logic                     out_frame_end,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [wmf_pkg::IDX_W-1:0] cfg_index,
  input  logic [wmf_pkg::DIM_W-1:0] cfg_data
);
  import wmf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_SETUP  = 7'b0000100,
    S_LOAD   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_SHIFT  = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_t;

  localparam logic [ADDR_W:0]  DEPTH_C = (ADDR_W+1)'(LS_DEPTH);
  localparam logic [DIM_W-1:0] MAXW_C  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH_C  = DIM_W'(MAX_HEIGHT);

  state_t state_r, state_nxt;

  logic [SPAN_W-1:0] span_r;
  logic [DIM_W-1:0]  width_r, height_r;
  logic [DIM_W-1:0]  eff_w_r, eff_h_r;
  logic [RAD_W-1:0]  rad_r;
  logic [POS_W-1:0]  total_r;
  logic [LAG_W-1:0]  lag_r;
  logic [1:0]        cfg_wait_r;

  logic [DIM_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r, out_row_r, out_col_r;
  logic [POS_W-1:0]  got_r, done_r;
  logic [ADDR_W-1:0] wptr_r, optr_r;
  logic              flush_r;

  logic [ADDR_W-1:0] addr_r, row_addr_r;
  logic [SIDE_W-1:0] nrows_r, ncols_r, xi_r, yi_r;
  logic [CNT_W-2:0]  sh_r;
  logic              rd_v_r;
  pix_t              rd_data_r;
  pix_t              mem [LS_DEPTH];

  pix_t              out_median_r;
  logic              out_frame_end_r, out_valid_r;

  logic              in_acc, cfg_acc, cfg_hit, wr_en, emit, last_out;
  wmf_cmd_t          cmd;
  pix_t              head;

  assign cfg_ready     = 1'b1;
  assign cfg_acc       = cfg_valid && cfg_ready;
  assign cfg_hit       = cfg_acc && (cfg_index == REG_SPAN || cfg_index == REG_WIDTH ||
                                     cfg_index == REG_HEIGHT);
  assign in_stall      = (state_r != S_IDLE) || (cfg_wait_r != 2'd0);
  assign in_acc        = in_valid && !in_stall;
  assign wr_en         = in_acc && (in_op == OP_PIXEL) && (in_row_r < eff_h_r);
  assign emit          = (state_r == S_HOLD) && (!out_valid_r || !out_stall);
  assign last_out      = (done_r == total_r - POS_W'(1));
  assign out_valid     = out_valid_r;
  assign out_median    = out_median_r;
  assign out_frame_end = out_frame_end_r;

  // Configuration registers and the derived sizes, two register stages deep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r     <= SPAN_W'(3);
      width_r    <= MAXW_C;
      height_r   <= MAXH_C;
      cfg_wait_r <= 2'd2;
    end else begin
      if (cfg_acc && cfg_index == REG_SPAN)   span_r   <= cfg_data[SPAN_W-1:0];
      if (cfg_acc && cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_acc && cfg_index == REG_HEIGHT) height_r <= cfg_data;
      if (cfg_hit) begin
        cfg_wait_r <= 2'd2;
      end else if (cfg_wait_r != 2'd0) begin
        cfg_wait_r <= cfg_wait_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eff_w_r <= (width_r == '0) ? DIM_W'(1) : ((width_r > MAXW_C) ? MAXW_C : width_r);
    eff_h_r <= (height_r == '0) ? DIM_W'(1) : ((height_r > MAXH_C) ? MAXH_C : height_r);
    rad_r   <= (span_r[SPAN_W-1:1] > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                          : RAD_W'(span_r[SPAN_W-1:1]);
    total_r <= POS_W'(eff_w_r) * POS_W'(eff_h_r);
    lag_r   <= LAG_W'(rad_r) * LAG_W'(eff_w_r) + LAG_W'(rad_r);
  end

  // Window geometry of the next output pixel.
  logic [RAD_W-1:0]  dy_up, dy_dn, dx_lf, dx_rt;
  logic [DIM_W-1:0]  h_left, w_left;
  logic [ADDR_W:0]   sub, start;
  logic [SIDE_W-1:0] nrows, ncols;
  logic [CNT_W-1:0]  n_win;

  always_comb begin
    h_left = eff_h_r - DIM_W'(1) - DIM_W'(out_row_r);
    w_left = eff_w_r - DIM_W'(1) - DIM_W'(out_col_r);
    dy_up  = (out_row_r < COL_W'(rad_r)) ? RAD_W'(out_row_r) : rad_r;
    dx_lf  = (out_col_r < COL_W'(rad_r)) ? RAD_W'(out_col_r) : rad_r;
    dy_dn  = (h_left < DIM_W'(rad_r)) ? RAD_W'(h_left) : rad_r;
    dx_rt  = (w_left < DIM_W'(rad_r)) ? RAD_W'(w_left) : rad_r;
    nrows  = SIDE_W'(dy_up) + SIDE_W'(dy_dn) + SIDE_W'(1);
    ncols  = SIDE_W'(dx_lf) + SIDE_W'(dx_rt) + SIDE_W'(1);
    n_win  = CNT_W'(nrows) * CNT_W'(ncols);
    sub    = (ADDR_W+1)'(dy_up) * (ADDR_W+1)'(eff_w_r) + (ADDR_W+1)'(dx_lf);
    start  = ({1'b0, optr_r} >= sub) ? ({1'b0, optr_r} - sub)
                                     : ({1'b0, optr_r} + DEPTH_C - sub);
  end

  logic [ADDR_W:0] addr_inc, row_inc;
  logic            row_end, win_end;

  always_comb begin
    addr_inc = {1'b0, addr_r} + (ADDR_W+1)'(1);
    if (addr_inc >= DEPTH_C) addr_inc = addr_inc - DEPTH_C;
    row_inc = {1'b0, row_addr_r} + (ADDR_W+1)'(eff_w_r);
    if (row_inc >= DEPTH_C) row_inc = row_inc - DEPTH_C;
    row_end = (xi_r == ncols_r - SIDE_W'(1));
    win_end = row_end && (yi_r == nrows_r - SIDE_W'(1));
  end

  logic ready_now;
  assign ready_now = (in_row_r >= eff_h_r) ||
    (!flush_r && ((POS_W+1)'(got_r) >=
                  (POS_W+1)'(done_r) + (POS_W+1)'(lag_r) + (POS_W+1)'(1)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_op == OP_FLUSH || wr_en)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = (done_r < total_r && ready_now) ? S_SETUP : S_IDLE;
      end
      S_SETUP: state_nxt = S_LOAD;
      S_LOAD:  if (win_end) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_SHIFT;
      S_SHIFT: if (sh_r == '0) state_nxt = S_HOLD;
      S_HOLD:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.clear  = (state_r == S_SETUP);
    cmd.insert = rd_v_r;
    cmd.shift  = (state_r == S_SHIFT) && (sh_r != '0);
  end

  wmf_sort_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .din   (rd_data_r),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr_r] <= in_sample;
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      got_r       <= '0;
      done_r      <= '0;
      wptr_r      <= '0;
      optr_r      <= '0;
      flush_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_LOAD);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) flush_r <= (in_op == OP_FLUSH);

      if (cfg_hit || (emit && last_out)) begin
        in_row_r  <= '0;
        in_col_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        got_r     <= '0;
        done_r    <= '0;
        wptr_r    <= '0;
        optr_r    <= '0;
      end else begin
        if (wr_en) begin
          got_r  <= got_r + POS_W'(1);
          wptr_r <= (wptr_r == ADDR_W'(LS_DEPTH - 1)) ? '0 : wptr_r + ADDR_W'(1);
          if (DIM_W'(in_col_r) + DIM_W'(1) >= eff_w_r) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + DIM_W'(1);
          end else begin
            in_col_r <= in_col_r + COL_W'(1);
          end
        end
        if (emit) begin
          done_r <= done_r + POS_W'(1);
          optr_r <= (optr_r == ADDR_W'(LS_DEPTH - 1)) ? '0 : optr_r + ADDR_W'(1);
          if (DIM_W'(out_col_r) + DIM_W'(1) >= eff_w_r) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + COL_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  // Window walk: one line store read per cycle, row by row.
  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      addr_r     <= start[ADDR_W-1:0];
      row_addr_r <= start[ADDR_W-1:0];
      nrows_r    <= nrows;
      ncols_r    <= ncols;
      xi_r       <= '0;
      yi_r       <= '0;
      sh_r       <= n_win[CNT_W-1:1];
    end else if (state_r == S_LOAD) begin
      if (row_end) begin
        xi_r       <= '0;
        yi_r       <= yi_r + SIDE_W'(1);
        row_addr_r <= row_inc[ADDR_W-1:0];
        addr_r     <= row_inc[ADDR_W-1:0];
      end else begin
        xi_r   <= xi_r + SIDE_W'(1);
        addr_r <= addr_inc[ADDR_W-1:0];
      end
    end else if (cmd.shift) begin
      sh_r <= sh_r - (CNT_W-1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_median_r    <= head;
      out_frame_end_r <= last_out;
    end
  end

  a_done_le_got: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= got_r)
    else $error("output position ran ahead of input position");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r < ADDR_W'(LS_DEPTH)) && (optr_r < ADDR_W'(LS_DEPTH)) &&
    (addr_r < ADDR_W'(LS_DEPTH) || state_r != S_LOAD))
    else $error("line store pointer out of range");

  a_read_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> ($past(state_r) == S_LOAD))
    else $error("sort insert without a line store read");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD || state_r == S_SHIFT) |-> !wr_en)
    else $error("line store written during window walk");

endmodule

// ----- rtl/wmf_sort_cell.sv -----
module wmf_sort_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  wmf_pkg::wmf_cmd_t cmd,
  input  wmf_pkg::pix_t   din,
  input  wmf_pkg::pix_t   prev_val,
  input  logic            prev_valid,
  input  logic            prev_gt,
  input  wmf_pkg::pix_t   next_val,
  input  logic            next_valid,
  output wmf_pkg::pix_t   val,
  output logic            valid,
  output logic            gt
);
  import wmf_pkg::*;

  pix_t val_r;
  logic valid_r;

  // An empty cell counts as holding a value above every sample.
  assign gt    = !valid_r || (val_r > din);
  assign val   = val_r;
  assign valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clear) begin
      valid_r <= 1'b0;
    end else if (cmd.insert && gt) begin
      valid_r <= prev_gt ? prev_valid : 1'b1;
    end else if (cmd.shift) begin
      valid_r <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && gt) begin
      val_r <= prev_gt ? prev_val : din;
    end else if (cmd.shift) begin
      val_r <= next_val;
    end
  end

endmodule

// ----- rtl/wmf_sort_chain.sv -----
module wmf_sort_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  wmf_pkg::wmf_cmd_t cmd,
  input  wmf_pkg::pix_t     din,
  output wmf_pkg::pix_t     head
);
  import wmf_pkg::*;

  pix_t val   [WIN_MAX];
  logic valid [WIN_MAX];
  logic gt    [WIN_MAX];

  // Ascending order from cell 0; an insert moves the upper part one cell on,
  // a shift moves everything one cell toward the head.
  for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
    pix_t p_val;
    logic p_valid;
    logic p_gt;
    pix_t n_val;
    logic n_valid;

    if (i == 0) begin : g_first
      assign p_val   = din;
      assign p_valid = 1'b0;
      assign p_gt    = 1'b0;
    end else begin : g_mid
      assign p_val   = val[i-1];
      assign p_valid = valid[i-1];
      assign p_gt    = gt[i-1];
    end

    if (i == WIN_MAX - 1) begin : g_last
      assign n_val   = val[i];
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_val   = val[i+1];
      assign n_valid = valid[i+1];
    end

    wmf_sort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .din        (din),
      .prev_val   (p_val),
      .prev_valid (p_valid),
      .prev_gt    (p_gt),
      .next_val   (n_val),
      .next_valid (n_valid),
      .val        (val[i]),
      .valid      (valid[i]),
      .gt         (gt[i])
    );
  end

  assign head = val[0];

  for (genvar i = 0; i < WIN_MAX - 1; i++) begin : g_chk
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
      valid[i+1] |-> valid[i])
      else $error("sort chain has a hole");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
      valid[i+1] |-> (val[i] <= val[i+1]))
      else $error("sort chain out of order");
  end

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> !valid[0])
    else $error("sort chain not cleared");

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wmf_pkg::*;

  typedef struct {
    logic op;
    pix_t sample;
  } pixel_item_t;

  typedef struct {
    pix_t median;
    logic frame_end;
  } median_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_op;
  logic [PIX_W-1:0]    in_sample;
  logic                out_valid;
  logic                out_stall;
  logic [PIX_W-1:0]    out_median;
  logic                out_frame_end;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [DIM_W-1:0]    cfg_data;

  window_median_filter dut (.*);

  pixel_item_t    pixel_q[$];
  median_result_t median_q[$];
  int             error_count = 0;

  // Shadow copy of the filter: registers, line store and positions.
  int   span_reg, width_reg, height_reg;
  pix_t shadow_store [LS_DEPTH];
  int   in_row, in_col, out_row, out_col;

  int   burst_left = 0, gap_left = 0;
  int   hold_left = 0, pat_left = 0, pat_pct = 0;
  bit   hold_req = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int clamp_dim(int v, int max_v);
    if (v < 1) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  function automatic int radius_now();
    int r;
    r = span_reg / 2;
    return (r > MAX_RADIUS) ? MAX_RADIUS : r;
  endfunction

  function automatic pix_t clipped_median(int r, int c, int w, int h, int rad);
    int   vals[WIN_MAX];
    int   n, y0, y1, x0, x1, v, j;
    n  = 0;
    y0 = (r > rad) ? r - rad : 0;
    y1 = (r + rad < h) ? r + rad : h - 1;
    x0 = (c > rad) ? c - rad : 0;
    x1 = (c + rad < w) ? c + rad : w - 1;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        v = shadow_store[(y * w + x) % LS_DEPTH];
        j = n;
        while (j > 0 && vals[j-1] > v) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = v;
        n++;
      end
    end
    return (n > 0) ? pix_t'(vals[n/2]) : '0;
  endfunction

  task automatic restart_positions();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endtask

  // Works out what one accepted item produces and queues it.
  task automatic predict_median(logic op, pix_t s);
    int             w, h, rad, total, lag, got, done;
    bit             ready_now;
    median_result_t res;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    rad = radius_now();
    total = w * h;
    lag = rad * w + rad;
    if (op == OP_PIXEL) begin
      if (in_row >= h) return;
      shadow_store[(in_row * w + in_col) % LS_DEPTH] = s;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    got = (in_row >= h) ? total : in_row * w + in_col;
    done = out_row * w + out_col;
    if (done >= total) return;
    ready_now = (got >= total) || (op == OP_PIXEL && got >= done + lag + 1);
    if (!ready_now) return;
    res.median = clipped_median(out_row, out_col, w, h, rad);
    res.frame_end = (done == total - 1);
    median_q.push_back(res);
    if (res.frame_end) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic report(string what, int got_v, int exp_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got_v, exp_v);
    error_count++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op <= OP_PIXEL;
      in_sample <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_median(in_op, in_sample);
        void'(pixel_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_op <= pixel_q[0].op;
          in_sample <= pixel_q[0].sample;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver stall: changing random patterns, plus an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: pat_pct = 0;
          1: pat_pct = 25;
          2: pat_pct = 60;
          default: pat_pct = 90;
        endcase
      end
      pat_left--;
      out_stall <= ($urandom_range(0, 99) < pat_pct);
    end
  end

  // Checker for each result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        report("unexpected result", out_median, -1);
      end else begin
        if (out_median !== median_q[0].median)
          report("median", out_median, median_q[0].median);
        if (out_frame_end !== median_q[0].frame_end)
          report("frame_end", out_frame_end, median_q[0].frame_end);
        void'(median_q.pop_front());
      end
    end
  end

  task automatic wait_idle();
    wait (pixel_q.size() == 0 && median_q.size() == 0);
    repeat (90) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SPAN) span_reg = value & 7;
    else if (idx == REG_WIDTH) width_reg = value & 'h7FF;
    else height_reg = value & 'h7FF;
    restart_positions();
    repeat (4) @(posedge clk);
  endtask

  task automatic setup(int span, int w, int h);
    wait_idle();
    write_reg(REG_SPAN, span);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Queues a whole frame and the flush ticks that drain it; noise_pct sets how
  // often a stray flush lands inside the frame.
  task automatic queue_frame(int noise_pct, bit stray_pixel);
    int w, h, rad;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    rad = radius_now();
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        pixel_q.push_back('{OP_FLUSH, pix_t'($urandom_range(0, 255))});
      pixel_q.push_back('{OP_PIXEL, rand_pixel()});
    end
    if (stray_pixel)
      pixel_q.push_back('{OP_PIXEL, rand_pixel()});
    for (int i = 0; i < rad * w + rad + 2; i++)
      pixel_q.push_back('{OP_FLUSH, pix_t'($urandom_range(0, 255))});
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SPAN;
    cfg_data = '0;
    span_reg = 3;
    width_reg = 1024;
    height_reg = 1024;
    restart_positions();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Directed: extreme values, flush inside a frame, pixel after the frame.
    setup(3, 4, 3);
    pixel_q.push_back('{OP_FLUSH, 8'h00});
    for (int i = 0; i < 12; i++)
      pixel_q.push_back('{OP_PIXEL, (i % 2) ? 8'hFF : 8'h00});
    pixel_q.push_back('{OP_FLUSH, 8'hFF});
    pixel_q.push_back('{OP_PIXEL, 8'hAA});
    for (int i = 0; i < 8; i++)
      pixel_q.push_back('{OP_FLUSH, 8'h55});
    setup(0, 0, 0);
    queue_frame(0, 1);
    setup(7, 3, 2);
    queue_frame(20, 0);

    // Sender pause in the middle of a frame until the block has drained.
    setup(6, 5, 4);
    for (int i = 0; i < 10; i++)
      pixel_q.push_back('{OP_PIXEL, rand_pixel()});
    wait (pixel_q.size() == 0 && median_q.size() == 0);
    for (int i = 0; i < 10; i++)
      pixel_q.push_back('{OP_PIXEL, rand_pixel()});
    for (int i = 0; i < 12; i++)
      pixel_q.push_back('{OP_FLUSH, 8'h00});

    // Long receiver hold-off while a frame keeps coming.
    setup(5, 8, 6);
    queue_frame(0, 0);
    hold_req = 1;

    // Oversized sizes clamp; the start of such a frame is cut short by the next write.
    setup(1, 2047, 2047);
    for (int i = 0; i < 20; i++)
      pixel_q.push_back('{OP_PIXEL, rand_pixel()});

    // Random frames with random content and some noise.
    sent = 0;
    while (sent < 120) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: write_reg(REG_SPAN, $urandom_range(0, 7));
        1: write_reg(REG_WIDTH, $urandom_range(1, 10));
        2: write_reg(REG_HEIGHT, $urandom_range(1, 9));
        default: begin
          write_reg(REG_SPAN, $urandom_range(0, 7));
          write_reg(REG_WIDTH, $urandom_range(1, 10));
          write_reg(REG_HEIGHT, $urandom_range(1, 9));
        end
      endcase
      for (int f = $urandom_range(1, 2); f > 0; f--) begin
        queue_frame(($urandom_range(0, 3) == 0) ? 10 : 0, $urandom_range(0, 4) == 0);
        sent += clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wmf_pkg.sv
rtl/wmf_sort_cell.sv
rtl/wmf_sort_chain.sv
rtl/window_median_filter.sv
verif/testbench.sv
